// File: hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// Text frame deframer package
// Shared constants and the result word type of the deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam logic [7:0] SYNC_A = 8'h02;
    localparam logic [7:0] SYNC_B = 8'h4D;
    localparam logic [7:0] SYNC_C = 8'h6C;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD_END = 2'd1,
        KIND_BAD_END  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] source_id;
        logic [7:0] dest_id;
        logic [7:0] payload_length;
        logic       frame_last;
    } tfd_result_t;

endpackage

// File: hdl/tfd_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the frame phase, header fields and running checksum, and forms the
// result word caused by the byte presented at the input.
// ----------------------------------------------------------------------------
module tfd_parser
    import tfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output tfd_result_t res
);

    typedef enum logic [3:0] {
        PH_HUNT0 = 4'd0,
        PH_HUNT1 = 4'd1,
        PH_HUNT2 = 4'd2,
        PH_HUNT3 = 4'd3,
        PH_DEST  = 4'd4,
        PH_SRC   = 4'd5,
        PH_LEN   = 4'd6,
        PH_DATA  = 4'd7,
        PH_CKLO  = 4'd8,
        PH_CKHI  = 4'd9
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  dst_reg, dst_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cklo_reg, cklo_next;
    logic [15:0] sum_add;
    logic [7:0]  left_dec;
    phase_t      restart;

    // The term (b xor 255) + b*256 never carries between its two halves.
    assign sum_add  = sum_reg + {rx_byte, ~rx_byte};
    assign left_dec = left_reg - 8'd1;
    assign restart  = (rx_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        len_next   = len_reg;
        cklo_next  = cklo_reg;
        res_valid  = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.data_byte      = 8'd0;
        res.source_id      = src_reg;
        res.dest_id        = dst_reg;
        res.payload_length = len_reg;
        res.frame_last     = 1'b0;
        unique case (phase_reg)
            PH_HUNT1: begin
                phase_next = (rx_byte == SYNC_B) ? PH_HUNT2 : restart;
            end
            PH_HUNT2: begin
                phase_next = (rx_byte == SYNC_C) ? PH_HUNT3 : restart;
            end
            PH_HUNT3: begin
                if (rx_byte == SYNC_A) begin
                    phase_next = PH_DEST;
                    sum_next   = 16'd0;
                end else begin
                    phase_next = PH_HUNT0;
                end
            end
            PH_DEST: begin
                dst_next   = rx_byte;
                sum_next   = sum_add;
                phase_next = PH_SRC;
            end
            PH_SRC: begin
                src_next   = rx_byte;
                sum_next   = sum_add;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                len_next   = rx_byte;
                left_next  = rx_byte;
                sum_next   = sum_add;
                phase_next = (rx_byte == 8'd0) ? PH_CKLO : PH_DATA;
            end
            PH_DATA: begin
                sum_next      = sum_add;
                left_next     = left_dec;
                phase_next    = (left_dec == 8'd0) ? PH_CKLO : PH_DATA;
                res_valid     = 1'b1;
                res.data_byte = rx_byte;
            end
            PH_CKLO: begin
                cklo_next  = rx_byte;
                phase_next = PH_CKHI;
            end
            PH_CKHI: begin
                phase_next     = PH_HUNT0;
                res_valid      = 1'b1;
                res.frame_last = 1'b1;
                res.kind = ({rx_byte, cklo_reg} == sum_reg) ? KIND_GOOD_END : KIND_BAD_END;
            end
            default: begin
                phase_next = restart;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT0;
            left_reg  <= 8'd0;
            sum_reg   <= 16'd0;
            src_reg   <= 8'd0;
            dst_reg   <= 8'd0;
            len_reg   <= 8'd0;
            cklo_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            len_reg   <= len_next;
            cklo_reg  <= cklo_next;
        end
    end

endmodule

// File: hdl/tfd_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result word until the downstream side takes it, and lets a new
// word load in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module tfd_out_reg
    import tfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  tfd_result_t load_word,
    output logic        can_load,
    output logic        m_valid,
    input  logic        m_ready,
    output tfd_result_t m_word
);

    logic        valid_reg, valid_next;
    tfd_result_t word_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

// File: hdl/text_frame_deframer.sv
// ----------------------------------------------------------------------------
// Text frame deframer
// Hunts for the sync header 02 4D 6C 02 in a received byte stream, then
// passes out each payload byte and one checksum verdict word per frame.
// ----------------------------------------------------------------------------
// A new input word can be taken every cycle while s_ready is high: the phase,
// header fields and 16-bit checksum update in a single pass between the state
// registers and the result register. The result register
// holds one word; while it is full and m_ready is low, s_ready is low.
// Header, address, length and checksum-low words produce no result word.
module text_frame_deframer
    import tfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_source_id,
    output logic [7:0] m_dest_id,
    output logic [7:0] m_payload_length,
    output logic       m_frame_last
);

    logic        accept;
    logic        res_valid;
    tfd_result_t res;
    tfd_result_t m_word;

    assign accept = s_valid && s_ready;

    tfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    tfd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && res_valid),
        .load_word (res),
        .can_load  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    assign m_kind           = m_word.kind;
    assign m_data_byte      = m_word.data_byte;
    assign m_source_id      = m_word.source_id;
    assign m_dest_id        = m_word.dest_id;
    assign m_payload_length = m_word.payload_length;
    assign m_frame_last     = m_word.frame_last;

`ifndef SYNTHESIS
    a_last_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_last == (m_kind != KIND_PAYLOAD)))
        else $error("frame_last disagrees with kind");

    a_end_has_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> (m_data_byte == 8'd0))
        else $error("frame end word carries data");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a blocked result");
`endif

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Text frame deframer testbench
// Drives received bytes through the valid/ready input channel and checks every
// result word against a cycle-free model of the deframer kept in the bench.
// Directed frames cover the header corner cases. Random frames, noise and
// broken headers follow, with random idling on both channels and a long
// receiver stall, and the run ends with a stretch without idling.
// ----------------------------------------------------------------------------
module testbench;
    import tfd_pkg::*;

    typedef enum logic [3:0] {
        HUNT_1ST  = 4'd0,
        HUNT_2ND  = 4'd1,
        HUNT_3RD  = 4'd2,
        HUNT_4TH  = 4'd3,
        GET_DEST  = 4'd4,
        GET_SRC   = 4'd5,
        GET_LEN   = 4'd6,
        GET_DATA  = 4'd7,
        GET_CK_LO = 4'd8,
        GET_CK_HI = 4'd9
    } deframe_phase_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_data_byte;
    logic [7:0] m_source_id;
    logic [7:0] m_dest_id;
    logic [7:0] m_payload_length;
    logic       m_frame_last;

    text_frame_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_source_id      (m_source_id),
        .m_dest_id        (m_dest_id),
        .m_payload_length (m_payload_length),
        .m_frame_last     (m_frame_last)
    );

    // Model state of the deframer.
    deframe_phase_t model_phase;
    logic [7:0]     model_left;
    logic [15:0]    model_sum;
    logic [7:0]     model_source;
    logic [7:0]     model_dest;
    logic [7:0]     model_length;
    logic [7:0]     model_ck_low;

    tfd_result_t expected_words[$];

    int  errors;
    int  mismatches;
    int  bytes_sent;
    int  payload_words_seen;
    int  good_ends_seen;
    int  bad_ends_seen;
    int  frames_built;
    bit  sender_idles;
    bit  receiver_idles;
    int  receiver_hold;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [15:0] sum_term(input logic [7:0] b);
        return {8'h00, b ^ 8'hFF} + {b, 8'h00};
    endfunction

    function automatic tfd_result_t frame_word(input kind_t k, input logic [7:0] d,
                                               input logic last);
        tfd_result_t w;
        w.kind           = k;
        w.data_byte      = d;
        w.source_id      = model_source;
        w.dest_id        = model_dest;
        w.payload_length = model_length;
        w.frame_last     = last;
        return w;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        deframe_phase_t restart;
        logic [15:0]    got;
        restart = (b == SYNC_A) ? HUNT_2ND : HUNT_1ST;
        case (model_phase)
            HUNT_2ND: model_phase = (b == SYNC_B) ? HUNT_3RD : restart;
            HUNT_3RD: model_phase = (b == SYNC_C) ? HUNT_4TH : restart;
            HUNT_4TH: begin
                if (b == SYNC_A) begin
                    model_phase = GET_DEST;
                    model_sum   = 16'h0000;
                end else begin
                    model_phase = HUNT_1ST;
                end
            end
            GET_DEST: begin
                model_dest  = b;
                model_sum   = model_sum + sum_term(b);
                model_phase = GET_SRC;
            end
            GET_SRC: begin
                model_source = b;
                model_sum    = model_sum + sum_term(b);
                model_phase  = GET_LEN;
            end
            GET_LEN: begin
                model_length = b;
                model_left   = b;
                model_sum    = model_sum + sum_term(b);
                model_phase  = (b == 8'h00) ? GET_CK_LO : GET_DATA;
            end
            GET_DATA: begin
                model_sum  = model_sum + sum_term(b);
                model_left = model_left - 8'd1;
                if (model_left == 8'h00) begin
                    model_phase = GET_CK_LO;
                end
                expected_words.push_back(frame_word(KIND_PAYLOAD, b, 1'b0));
            end
            GET_CK_LO: begin
                model_ck_low = b;
                model_phase  = GET_CK_HI;
            end
            GET_CK_HI: begin
                got         = {b, model_ck_low};
                model_phase = HUNT_1ST;
                expected_words.push_back(frame_word(
                    (got == model_sum) ? KIND_GOOD_END : KIND_BAD_END, 8'h00, 1'b1));
            end
            default: model_phase = restart;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge aclk);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    // Sends one frame; a nonzero corrupt mask spoils the checksum, and a
    // short count cuts the payload off early.
    task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                              input logic [7:0] len, input logic [15:0] corrupt,
                              input int keep);
        logic [15:0] sum;
        logic [7:0]  payload[$];
        logic [15:0] ck;
        int          n;
        sum = sum_term(dest) + sum_term(src) + sum_term(len);
        for (n = 0; n < len; n++) begin
            payload.push_back(8'($urandom_range(0, 255)));
            sum = sum + sum_term(payload[n]);
        end
        ck = sum ^ corrupt;
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(SYNC_A);
        send_byte(dest);
        send_byte(src);
        send_byte(len);
        for (n = 0; n < len && n < keep; n++) begin
            send_byte(payload[n]);
        end
        if (keep >= len) begin
            send_byte(ck[7:0]);
            send_byte(ck[15:8]);
        end
        frames_built++;
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return SYNC_A;
            1: return SYNC_B;
            2: return SYNC_C;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_frame();
        int          r;
        int          n;
        logic [7:0]  len;
        logic [15:0] corrupt;
        int          keep;
        r = $urandom_range(0, 99);
        if (r < 8) len = 8'd0;
        else if (r < 85) len = 8'($urandom_range(1, 8));
        else if (r < 98) len = 8'($urandom_range(9, 40));
        else len = 8'($urandom_range(200, 255));
        corrupt = 16'h0000;
        if ($urandom_range(0, 4) == 0) begin
            corrupt = 16'h0001 << $urandom_range(0, 15);
        end
        keep = 256;
        if ($urandom_range(0, 19) == 0) begin
            keep = $urandom_range(0, len);
        end
        r = $urandom_range(0, 9);
        if (r < 3) begin
            for (n = $urandom_range(1, 3); n > 0; n--) send_byte(noise_byte());
        end else if (r < 5) begin
            n = $urandom_range(1, 3);
            send_byte(SYNC_A);
            if (n > 1) send_byte(SYNC_B);
            if (n > 2) send_byte(SYNC_C);
            send_byte(noise_byte());
        end
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, corrupt,
                   keep);
    endtask

    // Receiver: random ready bursts, plus a long counted stall on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (receiver_hold > 0) begin
                m_ready = 1'b0;
                repeat (receiver_hold - 1) @(negedge aclk);
                receiver_hold = 0;
            end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        tfd_result_t seen;
        tfd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen.kind           = kind_t'(m_kind);
            seen.data_byte      = m_data_byte;
            seen.source_id      = m_source_id;
            seen.dest_id        = m_dest_id;
            seen.payload_length = m_payload_length;
            seen.frame_last     = m_frame_last;
            if (expected_words.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: kind %0d data %h src %h dst %h len %h last %b",
                             m_kind, m_data_byte, m_source_id, m_dest_id,
                             m_payload_length, m_frame_last);
                end
            end else begin
                want = expected_words.pop_front();
                if (seen.kind !== want.kind || seen.data_byte !== want.data_byte ||
                    seen.source_id !== want.source_id || seen.dest_id !== want.dest_id ||
                    seen.payload_length !== want.payload_length ||
                    seen.frame_last !== want.frame_last) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind %0d data %h src %h dst %h len %h last %b",
                                 want.kind, want.data_byte, want.source_id, want.dest_id,
                                 want.payload_length, want.frame_last);
                        $display("          actual   kind %0d data %h src %h dst %h len %h last %b",
                                 m_kind, m_data_byte, m_source_id, m_dest_id,
                                 m_payload_length, m_frame_last);
                    end
                end
                case (want.kind)
                    KIND_PAYLOAD:  payload_words_seen++;
                    KIND_GOOD_END: good_ends_seen++;
                    default:       bad_ends_seen++;
                endcase
            end
        end
    end

    // Junk, a sync byte breaking a partial header, a zero-length frame, then a
    // frame with extreme payload bytes and a bad checksum.
    task automatic test_directed();
        logic [15:0] sum;
        send_byte(SYNC_C);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(SYNC_A);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        sum = sum_term(8'hFF) + sum_term(8'h00) + sum_term(8'h00);
        send_byte(sum[7:0]);
        send_byte(sum[15:8]);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(SYNC_A);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        sum = sum_term(8'h00) + sum_term(8'hFF) + sum_term(8'h02)
            + sum_term(8'h00) + sum_term(8'hFF);
        sum = ~sum;
        send_byte(sum[7:0]);
        send_byte(sum[15:8]);
    endtask

    task automatic test_random_frames(input int target);
        while (bytes_sent < target) begin
            send_random_frame();
        end
    endtask

    task automatic test_backpressure();
        sender_idles  = 1'b0;
        receiver_hold = 300;
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd40,
                   16'h0000, 256);
        sender_idles  = 1'b1;
    endtask

    task automatic test_no_idle(input int target);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        while (bytes_sent < target) begin
            send_random_frame();
        end
    endtask

    initial begin
        int wait_cycles;
        errors             = 0;
        mismatches         = 0;
        bytes_sent         = 0;
        payload_words_seen = 0;
        good_ends_seen     = 0;
        bad_ends_seen      = 0;
        frames_built       = 0;
        sender_idles       = 1'b1;
        receiver_idles     = 1'b1;
        receiver_hold      = 0;
        model_phase        = HUNT_1ST;
        model_left         = 8'h00;
        model_sum          = 16'h0000;
        model_source       = 8'h00;
        model_dest         = 8'h00;
        model_length       = 8'h00;
        model_ck_low       = 8'h00;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_rx_byte          = 8'h00;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_frames(600);
        test_backpressure();
        test_random_frames(900);
        test_no_idle(1030);

        @(negedge aclk);
        s_valid = 1'b0;
        wait_cycles = 0;
        while (expected_words.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (10) @(posedge aclk);
        if (expected_words.size() != 0) begin
            errors++;
            $display("%0d result words never arrived", expected_words.size());
        end
        $display("Sent %0d bytes in %0d frames with noise and broken headers.",
                 bytes_sent, frames_built);
        $display("Checked %0d payload words, %0d good and %0d bad frame ends, %0d mismatches.",
                 payload_words_seen, good_ends_seen, bad_ends_seen, mismatches);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
